FILE: rtl/core/bpp_pkg.sv
// Shared types, register codes and saturation helper for the Boris pusher.
`default_nettype none

package bpp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_TO_MASS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_FIELD_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_FIELD_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_FIELD_Z    = 3'd6;

    localparam logic signed [31:0] RST_CHARGE_TO_MASS = 32'sd65536;
    localparam logic [30:0]        RST_TIME_STEP      = 31'd655;
    localparam logic [30:0]        RST_GRID_SPACING   = 31'd65536;
    localparam logic [10:0]        RST_GRID_COUNT     = 11'd1024;

    // divider width: |t| * 2^17 and 65536 + sum of t^2 both fit 49 bits
    localparam int DIV_W = 49;
    // rotation factor s is bounded by about one in Q16.16
    localparam int S_W   = 18;

    typedef struct packed {
        logic               mode;
        logic [9:0]         grid_index;
        logic signed [31:0] field_value;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic               in_grid;
    } result_t;

    typedef struct packed {
        req_t               req;
        logic signed [31:0] k;
        logic signed [31:0] t_x;
        logic signed [31:0] t_y;
        logic signed [31:0] t_z;
    } ctx_t;

    typedef struct packed {
        logic                  push;
        logic                  in_grid;
        req_t                  req;
        logic signed [31:0]    k;
        logic signed [31:0]    t_x;
        logic signed [31:0]    t_y;
        logic signed [31:0]    t_z;
        logic signed [S_W-1:0] s_x;
        logic signed [S_W-1:0] s_y;
        logic signed [S_W-1:0] s_z;
        logic signed [31:0]    ex;
    } gath_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -66'sd2147483648)
        begin
            return 32'sh80000000;
        end
        else
        begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/boris_particle_push_with_field_gather_unit.sv
// Top level of the Boris particle pusher with one-dimensional Ex gather.
//
// Requests enter on request when start is high and busy is low. A request
// with mode 0 writes one entry of the Ex table; mode 1 pushes a particle.
// A push gives one result on result, marked by done for a single cycle;
// loads give no result. A new request is taken every cycle while busy is
// low, and requests keep their order through the pipeline.
// A 49-stage divider finds cell and weight from pos_x / grid_spacing and,
// in parallel, the rotation factors s.
// Results cannot be held off: done is a strobe and must be taken at once.
// Registers are written through cfg_write, cfg_index and cfg_data. The user
// must write them only while no request is in flight; nothing enforces it.
// After reset the table is cleared, one entry a cycle, and busy stays high
// until every entry is cleared; register writes are taken during that time.
`default_nettype none

module boris_particle_push_with_field_gather_unit #(
    parameter int GRID_POINTS = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire bpp_pkg::req_t                     request,
    input  wire logic                              cfg_write,
    input  wire logic [bpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bpp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   done,
    output bpp_pkg::result_t                       result
);

    logic signed [31:0] c2m_reg;
    logic [30:0]        dt_reg;
    logic [30:0]        dx_reg;
    logic [10:0]        count_reg;
    logic signed [31:0] bx_reg;
    logic signed [31:0] by_reg;
    logic signed [31:0] bz_reg;

    logic accept;
    logic clearing;

    logic               s1_vld_reg;
    bpp_pkg::req_t      s1_req_reg;
    logic signed [63:0] s1_kprod_reg;

    logic signed [31:0] k_c;
    logic               s2_vld_reg;
    bpp_pkg::req_t      s2_req_reg;
    logic signed [31:0] s2_k_reg;
    logic signed [63:0] s2_tpx_reg;
    logic signed [63:0] s2_tpy_reg;
    logic signed [63:0] s2_tpz_reg;

    logic signed [31:0] tx_c;
    logic signed [31:0] ty_c;
    logic signed [31:0] tz_c;
    logic               s3_vld_reg;
    bpp_pkg::req_t      s3_req_reg;
    logic signed [31:0] s3_k_reg;
    logic signed [31:0] s3_tx_reg;
    logic signed [31:0] s3_ty_reg;
    logic signed [31:0] s3_tz_reg;
    logic signed [63:0] s3_ttx_reg;
    logic signed [63:0] s3_tty_reg;
    logic signed [63:0] s3_ttz_reg;

    logic [bpp_pkg::DIV_W-1:0] tsq;
    logic [bpp_pkg::DIV_W-1:0] den_s;
    logic [31:0]               mag_x;
    logic [31:0]               mag_y;
    logic [31:0]               mag_z;
    logic [30:0]               dx_eff;
    logic [bpp_pkg::DIV_W-1:0] num_x;
    logic [bpp_pkg::DIV_W-1:0] den_x;
    bpp_pkg::ctx_t             ctx_c;

    logic                      dvx_vld;
    logic [bpp_pkg::DIV_W-1:0] dvx_quot;
    bpp_pkg::ctx_t             dvx_ctx;
    logic [bpp_pkg::DIV_W-1:0] dsx_quot;
    logic [bpp_pkg::DIV_W-1:0] dsy_quot;
    logic [bpp_pkg::DIV_W-1:0] dsz_quot;
    logic                      dsx_neg;
    logic                      dsy_neg;
    logic                      dsz_neg;

    logic [32:0]    cnt;
    logic           g_vld;
    bpp_pkg::gath_t g_pay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2m_reg   <= bpp_pkg::RST_CHARGE_TO_MASS;
            dt_reg    <= bpp_pkg::RST_TIME_STEP;
            dx_reg    <= bpp_pkg::RST_GRID_SPACING;
            count_reg <= bpp_pkg::RST_GRID_COUNT;
            bx_reg    <= '0;
            by_reg    <= '0;
            bz_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bpp_pkg::CFG_CHARGE_TO_MASS: c2m_reg   <= $signed(cfg_data);
                bpp_pkg::CFG_TIME_STEP:      dt_reg    <= cfg_data[30:0];
                bpp_pkg::CFG_GRID_SPACING:   dx_reg    <= cfg_data[30:0];
                bpp_pkg::CFG_GRID_COUNT:     count_reg <= cfg_data[10:0];
                bpp_pkg::CFG_MAG_FIELD_X:    bx_reg    <= $signed(cfg_data);
                bpp_pkg::CFG_MAG_FIELD_Y:    by_reg    <= $signed(cfg_data);
                bpp_pkg::CFG_MAG_FIELD_Z:    bz_reg    <= $signed(cfg_data);
                default:                     ;
            endcase
        end
    end

    assign busy   = clearing;
    assign accept = start && !clearing;

    assign k_c  = bpp_pkg::sat32(66'(s1_kprod_reg >>> 17));
    assign tx_c = bpp_pkg::sat32(66'(s2_tpx_reg >>> 16));
    assign ty_c = bpp_pkg::sat32(66'(s2_tpy_reg >>> 16));
    assign tz_c = bpp_pkg::sat32(66'(s2_tpz_reg >>> 16));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg   <= request;
        s1_kprod_reg <= c2m_reg * $signed({1'b0, dt_reg});

        s2_req_reg <= s1_req_reg;
        s2_k_reg   <= k_c;
        s2_tpx_reg <= k_c * bx_reg;
        s2_tpy_reg <= k_c * by_reg;
        s2_tpz_reg <= k_c * bz_reg;

        s3_req_reg <= s2_req_reg;
        s3_k_reg   <= s2_k_reg;
        s3_tx_reg  <= tx_c;
        s3_ty_reg  <= ty_c;
        s3_tz_reg  <= tz_c;
        s3_ttx_reg <= tx_c * tx_c;
        s3_tty_reg <= ty_c * ty_c;
        s3_ttz_reg <= tz_c * tz_c;
    end

    // squares are never negative, so floor by 2^16 is a plain shift
    assign tsq   = {1'b0, s3_ttx_reg[63:16]} + {1'b0, s3_tty_reg[63:16]}
                   + {1'b0, s3_ttz_reg[63:16]};
    assign den_s = tsq + 49'd65536;
    assign mag_x = s3_tx_reg[31] ? 32'(-s3_tx_reg) : 32'(s3_tx_reg);
    assign mag_y = s3_ty_reg[31] ? 32'(-s3_ty_reg) : 32'(s3_ty_reg);
    assign mag_z = s3_tz_reg[31] ? 32'(-s3_tz_reg) : 32'(s3_tz_reg);

    // one divide gives cell in the upper bits and weight in the low 16
    assign dx_eff = (dx_reg == 31'd0) ? 31'd1 : dx_reg;
    assign num_x  = {2'b00, s3_req_reg.pos_x[30:0], 16'd0};
    assign den_x  = {18'd0, dx_eff};

    assign ctx_c = '{req: s3_req_reg, k: s3_k_reg, t_x: s3_tx_reg,
                     t_y: s3_ty_reg, t_z: s3_tz_reg};

    bpp_div_pipe #(
        .NW (bpp_pkg::DIV_W),
        .DW (bpp_pkg::DIV_W),
        .SW ($bits(bpp_pkg::ctx_t))
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s3_vld_reg),
        .num      (num_x),
        .den      (den_x),
        .side_in  (ctx_c),
        .out_vld  (dvx_vld),
        .quot     (dvx_quot),
        .side_out (dvx_ctx)
    );

    bpp_div_pipe #(
        .NW (bpp_pkg::DIV_W),
        .DW (bpp_pkg::DIV_W),
        .SW (1)
    ) u_div_sx (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s3_vld_reg),
        .num      ({mag_x, 17'd0}),
        .den      (den_s),
        .side_in  (s3_tx_reg[31]),
        .out_vld  (),
        .quot     (dsx_quot),
        .side_out (dsx_neg)
    );

    bpp_div_pipe #(
        .NW (bpp_pkg::DIV_W),
        .DW (bpp_pkg::DIV_W),
        .SW (1)
    ) u_div_sy (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s3_vld_reg),
        .num      ({mag_y, 17'd0}),
        .den      (den_s),
        .side_in  (s3_ty_reg[31]),
        .out_vld  (),
        .quot     (dsy_quot),
        .side_out (dsy_neg)
    );

    bpp_div_pipe #(
        .NW (bpp_pkg::DIV_W),
        .DW (bpp_pkg::DIV_W),
        .SW (1)
    ) u_div_sz (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s3_vld_reg),
        .num      ({mag_z, 17'd0}),
        .den      (den_s),
        .side_in  (s3_tz_reg[31]),
        .out_vld  (),
        .quot     (dsz_quot),
        .side_out (dsz_neg)
    );

    assign cnt = (33'(count_reg) < 33'(GRID_POINTS)) ? 33'(count_reg) : 33'(GRID_POINTS);

    bpp_gather #(
        .GRID_POINTS (GRID_POINTS)
    ) u_gather (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (dvx_vld),
        .quot_x   (dvx_quot),
        .ctx      (dvx_ctx),
        .quot_sx  (dsx_quot),
        .quot_sy  (dsy_quot),
        .quot_sz  (dsz_quot),
        .neg_sx   (dsx_neg),
        .neg_sy   (dsy_neg),
        .neg_sz   (dsz_neg),
        .cnt      (cnt),
        .clearing (clearing),
        .out_vld  (g_vld),
        .out_pay  (g_pay)
    );

    bpp_boris u_boris (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (g_vld),
        .in_pay    (g_pay),
        .time_step (dt_reg),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/bpp_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module bpp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

FILE: rtl/core/bpp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
`default_nettype none

module bpp_div_pipe #(
    parameter int NW = 49,
    parameter int DW = 49,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_vld,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] side_in,
    output logic               out_vld,
    output logic      [NW-1:0] quot,
    output logic      [SW-1:0] side_out
);

    logic          vld_reg  [0:NW-1];
    logic [DW-1:0] rem_reg  [0:NW-1];
    logic [NW-1:0] num_reg  [0:NW-1];
    logic [NW-1:0] quo_reg  [0:NW-1];
    logic [DW-1:0] den_reg  [0:NW-1];
    logic [SW-1:0] side_reg [0:NW-1];

    genvar g;
    generate
        for (g = 0; g < NW; g++)
        begin : g_stage
            logic          vld_s;
            logic [DW-1:0] rem_s;
            logic [NW-1:0] num_s;
            logic [NW-1:0] quo_s;
            logic [DW-1:0] den_s;
            logic [SW-1:0] side_s;
            logic [DW:0]   trial;
            logic          ge;

            if (g == 0)
            begin : g_head
                assign vld_s  = in_vld;
                assign rem_s  = '0;
                assign num_s  = num;
                assign quo_s  = '0;
                assign den_s  = den;
                assign side_s = side_in;
            end
            else
            begin : g_tail
                assign vld_s  = vld_reg[g-1];
                assign rem_s  = rem_reg[g-1];
                assign num_s  = num_reg[g-1];
                assign quo_s  = quo_reg[g-1];
                assign den_s  = den_reg[g-1];
                assign side_s = side_reg[g-1];
            end

            assign trial = {rem_s, num_s[NW-1]};
            assign ge    = (trial >= {1'b0, den_s});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g] <= 1'b0;
                end
                else
                begin
                    vld_reg[g] <= vld_s;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= ge ? DW'(trial - {1'b0, den_s}) : trial[DW-1:0];
                num_reg[g]  <= num_s << 1;
                quo_reg[g]  <= {quo_s[NW-2:0], ge};
                den_reg[g]  <= den_s;
                side_reg[g] <= side_s;
            end
        end
    endgenerate

    assign out_vld  = vld_reg[NW-1];
    assign quot     = quo_reg[NW-1];
    assign side_out = side_reg[NW-1];

endmodule

`default_nettype wire

FILE: rtl/core/bpp_gather.sv
// Field table, cell lookup and linear interpolation of Ex.
`default_nettype none

module bpp_gather #(
    parameter int GRID_POINTS = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_vld,
    input  wire logic [bpp_pkg::DIV_W-1:0]   quot_x,
    input  wire bpp_pkg::ctx_t               ctx,
    input  wire logic [bpp_pkg::DIV_W-1:0]   quot_sx,
    input  wire logic [bpp_pkg::DIV_W-1:0]   quot_sy,
    input  wire logic [bpp_pkg::DIV_W-1:0]   quot_sz,
    input  wire logic                        neg_sx,
    input  wire logic                        neg_sy,
    input  wire logic                        neg_sz,
    input  wire logic [32:0]                 cnt,
    output logic                             clearing,
    output logic                             out_vld,
    output bpp_pkg::gath_t                   out_pay
);

    localparam int AW = $clog2(GRID_POINTS);

    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [32:0]   cell_idx;
    logic [15:0]   wgt;
    logic          outside;
    logic          upper_ok;
    logic          load_we;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [31:0]   rdata_a;
    logic [31:0]   rdata_b;
    bpp_pkg::gath_t pay_c;

    logic           g1_vld_reg;
    bpp_pkg::gath_t g1_pay_reg;
    logic [15:0]    g1_wgt_reg;
    logic           g1_upper_reg;

    logic signed [31:0] e_hi;
    logic signed [49:0] prod_lo_c;
    logic signed [49:0] prod_hi_c;

    logic               g2_vld_reg;
    bpp_pkg::gath_t     g2_pay_reg;
    logic signed [49:0] g2_prod_lo_reg;
    logic signed [49:0] g2_prod_hi_reg;

    logic signed [50:0] sum_c;
    bpp_pkg::gath_t     out_pay_c;

    logic           out_vld_reg;
    bpp_pkg::gath_t out_pay_reg;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == AW'(GRID_POINTS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign clearing = clr_active_reg;

    assign cell_idx = quot_x[48:16];
    assign wgt      = quot_x[15:0];
    assign outside  = ctx.req.pos_x[31] || (cell_idx >= cnt);
    assign upper_ok = ((34'(cell_idx) + 34'd1) < 34'(cnt));

    assign load_we   = in_vld && !ctx.req.mode
                       && (32'(ctx.req.grid_index) < 32'(GRID_POINTS));
    assign ram_we    = clr_active_reg || load_we;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : AW'(ctx.req.grid_index);
    assign ram_wdata = clr_active_reg ? 32'd0 : ctx.req.field_value;
    assign raddr_a   = cell_idx[AW-1:0];
    assign raddr_b   = cell_idx[AW-1:0] + 1'b1;

    bpp_ram #(
        .WIDTH (32),
        .DEPTH (GRID_POINTS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        pay_c         = '0;
        pay_c.push    = ctx.req.mode;
        pay_c.in_grid = !outside;
        pay_c.req     = ctx.req;
        pay_c.k       = ctx.k;
        pay_c.t_x     = ctx.t_x;
        pay_c.t_y     = ctx.t_y;
        pay_c.t_z     = ctx.t_z;
        pay_c.s_x     = neg_sx ? -$signed({1'b0, quot_sx[16:0]}) : $signed({1'b0, quot_sx[16:0]});
        pay_c.s_y     = neg_sy ? -$signed({1'b0, quot_sy[16:0]}) : $signed({1'b0, quot_sy[16:0]});
        pay_c.s_z     = neg_sz ? -$signed({1'b0, quot_sz[16:0]}) : $signed({1'b0, quot_sz[16:0]});
    end

    assign e_hi      = g1_upper_reg ? $signed(rdata_b) : 32'sd0;
    assign prod_lo_c = $signed(rdata_a) * $signed({1'b0, 17'(17'h10000 - {1'b0, g1_wgt_reg})});
    assign prod_hi_c = e_hi * $signed({2'b00, g1_wgt_reg});
    assign sum_c     = 51'(g2_prod_lo_reg) + 51'(g2_prod_hi_reg);

    always_comb
    begin
        out_pay_c    = g2_pay_reg;
        out_pay_c.ex = sum_c[47:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_vld_reg  <= 1'b0;
            g2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            g1_vld_reg  <= in_vld;
            g2_vld_reg  <= g1_vld_reg;
            out_vld_reg <= g2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g1_pay_reg     <= pay_c;
        g1_wgt_reg     <= wgt;
        g1_upper_reg   <= upper_ok;
        g2_pay_reg     <= g1_pay_reg;
        g2_prod_lo_reg <= prod_lo_c;
        g2_prod_hi_reg <= prod_hi_c;
        out_pay_reg    <= out_pay_c;
    end

    assign out_vld = out_vld_reg;
    assign out_pay = out_pay_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bpp_boris.sv
// Boris velocity update and position drift, pipelined.
`default_nettype none

module bpp_boris (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_vld,
    input  wire bpp_pkg::gath_t  in_pay,
    input  wire logic [30:0]     time_step,
    output logic                 done,
    output bpp_pkg::result_t     result
);

    logic b1_vld_reg, b2_vld_reg, b3_vld_reg, b4_vld_reg;
    logic b5_vld_reg, b6_vld_reg, b7_vld_reg, b8_vld_reg;
    logic done_reg;

    bpp_pkg::gath_t b1_pay_reg, b2_pay_reg, b3_pay_reg, b4_pay_reg;
    bpp_pkg::gath_t b5_pay_reg, b6_pay_reg, b7_pay_reg, b8_pay_reg;

    logic signed [63:0] b1_kprod_reg;
    logic signed [31:0] ke_c;
    logic signed [31:0] b2_ke_reg, b3_ke_reg, b4_ke_reg, b5_ke_reg, b6_ke_reg;
    logic signed [31:0] b2_vm0_reg, b3_vm0_reg, b4_vm0_reg, b5_vm0_reg;

    logic signed [63:0] b3_p0a_reg, b3_p0b_reg, b3_p1a_reg;
    logic signed [63:0] b3_p1b_reg, b3_p2a_reg, b3_p2b_reg;
    logic signed [31:0] b4_vq0_reg, b4_vq1_reg, b4_vq2_reg;
    logic signed [49:0] b5_q0a_reg, b5_q0b_reg, b5_q1a_reg;
    logic signed [49:0] b5_q1b_reg, b5_q2a_reg, b5_q2b_reg;
    logic signed [31:0] b6_vp0_reg, b6_vp1_reg, b6_vp2_reg;
    logic signed [31:0] b7_vf0_reg, b7_vf1_reg, b7_vf2_reg;
    logic signed [31:0] b8_vf0_reg, b8_vf1_reg, b8_vf2_reg;
    logic signed [63:0] b8_d0_reg, b8_d1_reg, b8_d2_reg;

    logic signed [31:0] dt_s;
    bpp_pkg::result_t   res_c;
    bpp_pkg::result_t   result_reg;

    assign dt_s = $signed({1'b0, time_step});
    assign ke_c = bpp_pkg::sat32(66'(b1_kprod_reg >>> 16));

    always_comb
    begin
        if (b8_pay_reg.in_grid)
        begin
            res_c.new_vel_x = b8_vf0_reg;
            res_c.new_vel_y = b8_vf1_reg;
            res_c.new_vel_z = b8_vf2_reg;
            res_c.new_pos_x = bpp_pkg::sat32(66'(b8_pay_reg.req.pos_x) + 66'(b8_d0_reg >>> 16));
            res_c.new_pos_y = bpp_pkg::sat32(66'(b8_pay_reg.req.pos_y) + 66'(b8_d1_reg >>> 16));
            res_c.new_pos_z = bpp_pkg::sat32(66'(b8_pay_reg.req.pos_z) + 66'(b8_d2_reg >>> 16));
            res_c.in_grid   = 1'b1;
        end
        else
        begin
            res_c.new_vel_x = b8_pay_reg.req.vel_x;
            res_c.new_vel_y = b8_pay_reg.req.vel_y;
            res_c.new_vel_z = b8_pay_reg.req.vel_z;
            res_c.new_pos_x = b8_pay_reg.req.pos_x;
            res_c.new_pos_y = b8_pay_reg.req.pos_y;
            res_c.new_pos_z = b8_pay_reg.req.pos_z;
            res_c.in_grid   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            b4_vld_reg <= 1'b0;
            b5_vld_reg <= 1'b0;
            b6_vld_reg <= 1'b0;
            b7_vld_reg <= 1'b0;
            b8_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            b1_vld_reg <= in_vld;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
            b4_vld_reg <= b3_vld_reg;
            b5_vld_reg <= b4_vld_reg;
            b6_vld_reg <= b5_vld_reg;
            b7_vld_reg <= b6_vld_reg;
            b8_vld_reg <= b7_vld_reg;
            done_reg   <= b8_vld_reg && b8_pay_reg.push;
        end
    end

    always_ff @(posedge clk)
    begin
        // k * Ex
        b1_pay_reg   <= in_pay;
        b1_kprod_reg <= in_pay.k * in_pay.ex;

        // first half kick
        b2_pay_reg <= b1_pay_reg;
        b2_ke_reg  <= ke_c;
        b2_vm0_reg <= bpp_pkg::sat32(66'(b1_pay_reg.req.vel_x) + 66'(ke_c));

        // v- x t
        b3_pay_reg <= b2_pay_reg;
        b3_ke_reg  <= b2_ke_reg;
        b3_vm0_reg <= b2_vm0_reg;
        b3_p0a_reg <= b2_pay_reg.req.vel_y * b2_pay_reg.t_z;
        b3_p0b_reg <= b2_pay_reg.req.vel_z * b2_pay_reg.t_y;
        b3_p1a_reg <= b2_pay_reg.req.vel_z * b2_pay_reg.t_x;
        b3_p1b_reg <= b2_vm0_reg * b2_pay_reg.t_z;
        b3_p2a_reg <= b2_vm0_reg * b2_pay_reg.t_y;
        b3_p2b_reg <= b2_pay_reg.req.vel_y * b2_pay_reg.t_x;

        b4_pay_reg <= b3_pay_reg;
        b4_ke_reg  <= b3_ke_reg;
        b4_vm0_reg <= b3_vm0_reg;
        b4_vq0_reg <= bpp_pkg::sat32(66'(b3_vm0_reg) + 66'(b3_p0a_reg >>> 16)
                                     - 66'(b3_p0b_reg >>> 16));
        b4_vq1_reg <= bpp_pkg::sat32(66'(b3_pay_reg.req.vel_y) + 66'(b3_p1a_reg >>> 16)
                                     - 66'(b3_p1b_reg >>> 16));
        b4_vq2_reg <= bpp_pkg::sat32(66'(b3_pay_reg.req.vel_z) + 66'(b3_p2a_reg >>> 16)
                                     - 66'(b3_p2b_reg >>> 16));

        // v' x s
        b5_pay_reg <= b4_pay_reg;
        b5_ke_reg  <= b4_ke_reg;
        b5_vm0_reg <= b4_vm0_reg;
        b5_q0a_reg <= b4_vq1_reg * b4_pay_reg.s_z;
        b5_q0b_reg <= b4_vq2_reg * b4_pay_reg.s_y;
        b5_q1a_reg <= b4_vq2_reg * b4_pay_reg.s_x;
        b5_q1b_reg <= b4_vq0_reg * b4_pay_reg.s_z;
        b5_q2a_reg <= b4_vq0_reg * b4_pay_reg.s_y;
        b5_q2b_reg <= b4_vq1_reg * b4_pay_reg.s_x;

        b6_pay_reg <= b5_pay_reg;
        b6_ke_reg  <= b5_ke_reg;
        b6_vp0_reg <= bpp_pkg::sat32(66'(b5_vm0_reg) + 66'(b5_q0a_reg >>> 16)
                                     - 66'(b5_q0b_reg >>> 16));
        b6_vp1_reg <= bpp_pkg::sat32(66'(b5_pay_reg.req.vel_y) + 66'(b5_q1a_reg >>> 16)
                                     - 66'(b5_q1b_reg >>> 16));
        b6_vp2_reg <= bpp_pkg::sat32(66'(b5_pay_reg.req.vel_z) + 66'(b5_q2a_reg >>> 16)
                                     - 66'(b5_q2b_reg >>> 16));

        // second half kick
        b7_pay_reg <= b6_pay_reg;
        b7_vf0_reg <= bpp_pkg::sat32(66'(b6_vp0_reg) + 66'(b6_ke_reg));
        b7_vf1_reg <= b6_vp1_reg;
        b7_vf2_reg <= b6_vp2_reg;

        // drift
        b8_pay_reg <= b7_pay_reg;
        b8_vf0_reg <= b7_vf0_reg;
        b8_vf1_reg <= b7_vf1_reg;
        b8_vf2_reg <= b7_vf2_reg;
        b8_d0_reg  <= b7_vf0_reg * dt_s;
        b8_d1_reg  <= b7_vf1_reg * dt_s;
        b8_d2_reg  <= b7_vf2_reg * dt_s;

        result_reg <= res_c;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: bench/boris_particle_push_with_field_gather_unit_tb.sv
// Self-checking testbench for the Boris pusher: table loads, pushes and register phases.
`timescale 1ns / 1ps

module boris_particle_push_with_field_gather_unit_tb;

    localparam int  TABLE_DEPTH = 1024;
    localparam int  SETTLE      = 100;
    localparam int  CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {OP_REQUEST, OP_REGISTER, OP_DRAIN} op_kind_t;

    typedef struct {
        op_kind_t                                kind;
        int                                      gap;
        bpp_pkg::req_t                           req;
        logic [bpp_pkg::CFG_IDX_W-1:0]           idx;
        logic [bpp_pkg::CFG_DATA_W-1:0]          data;
    } pending_op_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    bpp_pkg::req_t                    request = '0;
    logic                             cfg_write = 1'b0;
    logic [bpp_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [bpp_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                             done;
    bpp_pkg::result_t                 result;

    pending_op_t      pending_ops[$];
    bpp_pkg::result_t expected_results[$];

    // push-side register and table copy
    longint field_table[TABLE_DEPTH];
    longint qm_reg, dt_reg, dx_reg, cnt_reg, bx_reg, by_reg, bz_reg;
    // generator-side copy used to aim positions into the grid
    longint gen_dx, gen_cnt;

    int  errors = 0;
    int  pushes_checked = 0;
    int  loads_sent = 0;
    int  outside_seen = 0;
    int  cycles = 0;
    bit  taken = 1'b0;
    int  gap_left = 0;
    int  drain_left = 0;

    boris_particle_push_with_field_gather_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always #2 clk = ~clk;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void cross_q(input longint a[3], input longint b[3], output longint r[3]);
        r[0] = ((a[1] * b[2]) >>> 16) - ((a[2] * b[1]) >>> 16);
        r[1] = ((a[2] * b[0]) >>> 16) - ((a[0] * b[2]) >>> 16);
        r[2] = ((a[0] * b[1]) >>> 16) - ((a[1] * b[0]) >>> 16);
    endfunction

    function automatic bpp_pkg::result_t boris_push(input bpp_pkg::req_t r);
        longint  v[3], p[3], vm[3], vq[3], vp[3], t[3], s[3], c[3], b[3];
        longint  dx, cnt, a, rem, w, ea, eb, ex, k, ke, tsq, np;
        bpp_pkg::result_t res;
        v[0] = r.vel_x;
        v[1] = r.vel_y;
        v[2] = r.vel_z;
        p[0] = r.pos_x;
        p[1] = r.pos_y;
        p[2] = r.pos_z;
        dx  = (dx_reg == 0) ? 1 : dx_reg;
        cnt = (cnt_reg < TABLE_DEPTH) ? cnt_reg : TABLE_DEPTH;
        if (p[0] < 0 || p[0] / dx >= cnt)
        begin
            res = {r.vel_x, r.vel_y, r.vel_z, r.pos_x, r.pos_y, r.pos_z, 1'b0};
            return res;
        end
        a   = p[0] / dx;
        rem = p[0] - a * dx;
        w   = (rem << 16) / dx;
        ea  = field_table[a];
        eb  = (a + 1 < cnt) ? field_table[a + 1] : 0;
        ex  = (ea * (65536 - w) + eb * w) >>> 16;
        k   = clamp32((qm_reg * dt_reg) >>> 17);
        ke  = clamp32((k * ex) >>> 16);
        b[0] = bx_reg;
        b[1] = by_reg;
        b[2] = bz_reg;
        tsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            t[i] = clamp32((k * b[i]) >>> 16);
            tsq += (t[i] * t[i]) >>> 16;
        end
        for (int i = 0; i < 3; i++)
        begin
            s[i] = (t[i] * 131072) / (65536 + tsq);
        end
        vm[0] = clamp32(v[0] + ke);
        vm[1] = v[1];
        vm[2] = v[2];
        cross_q(vm, t, c);
        for (int i = 0; i < 3; i++)
        begin
            vq[i] = clamp32(vm[i] + c[i]);
        end
        cross_q(vq, s, c);
        for (int i = 0; i < 3; i++)
        begin
            vp[i] = clamp32(vm[i] + c[i]);
        end
        vp[0] = clamp32(vp[0] + ke);
        res.new_vel_x = vp[0][31:0];
        res.new_vel_y = vp[1][31:0];
        res.new_vel_z = vp[2][31:0];
        np = clamp32(p[0] + ((vp[0] * dt_reg) >>> 16));
        res.new_pos_x = np[31:0];
        np = clamp32(p[1] + ((vp[1] * dt_reg) >>> 16));
        res.new_pos_y = np[31:0];
        np = clamp32(p[2] + ((vp[2] * dt_reg) >>> 16));
        res.new_pos_z = np[31:0];
        res.in_grid = 1'b1;
        return res;
    endfunction

    // register writes and accepted requests update the push-side state
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("boris_particle_push_with_field_gather_unit: mismatch");
            $finish;
        end
        taken <= start && !busy;
        if (rst_n && cfg_write)
        begin
            case (cfg_index)
                bpp_pkg::CFG_CHARGE_TO_MASS: qm_reg  = longint'($signed(cfg_data));
                bpp_pkg::CFG_TIME_STEP:      dt_reg  = cfg_data[30:0];
                bpp_pkg::CFG_GRID_SPACING:   dx_reg  = cfg_data[30:0];
                bpp_pkg::CFG_GRID_COUNT:     cnt_reg = cfg_data[10:0];
                bpp_pkg::CFG_MAG_FIELD_X:    bx_reg  = longint'($signed(cfg_data));
                bpp_pkg::CFG_MAG_FIELD_Y:    by_reg  = longint'($signed(cfg_data));
                bpp_pkg::CFG_MAG_FIELD_Z:    bz_reg  = longint'($signed(cfg_data));
                default: ;
            endcase
        end
        if (rst_n && start && !busy)
        begin
            if (request.mode)
            begin
                expected_results.push_back(boris_push(request));
            end
            else
            begin
                field_table[request.grid_index] = longint'(request.field_value);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        bpp_pkg::result_t want;
        logic [31:0]      got_f[6];
        logic [31:0]      want_f[6];
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: expected no result, actual %h", $time, result);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                got_f  = '{result.new_vel_x, result.new_vel_y, result.new_vel_z,
                           result.new_pos_x, result.new_pos_y, result.new_pos_z};
                want_f = '{want.new_vel_x, want.new_vel_y, want.new_vel_z,
                           want.new_pos_x, want.new_pos_y, want.new_pos_z};
                for (int i = 0; i < 6; i++)
                begin
                    if (got_f[i] !== want_f[i])
                    begin
                        $display("%0t: field %0d expected %h actual %h",
                                 $time, i, want_f[i], got_f[i]);
                        errors++;
                    end
                end
                if (result.in_grid !== want.in_grid)
                begin
                    $display("%0t: in_grid expected %b actual %b",
                             $time, want.in_grid, result.in_grid);
                    errors++;
                end
                pushes_checked++;
                if (!want.in_grid)
                begin
                    outside_seen++;
                end
            end
        end
    end

    // request and register-write driver
    always @(negedge clk)
    begin
        pending_op_t op;
        logic        nxt_start;
        logic        nxt_cfg_write;
        nxt_start     = 1'b0;
        nxt_cfg_write = 1'b0;
        if (!rst_n)
        begin
            nxt_start = 1'b0;
        end
        else if (start && !taken)
        begin
            nxt_start = 1'b1;
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
        end
        else if (drain_left > 0)
        begin
            drain_left <= (expected_results.size() != 0) ? SETTLE : drain_left - 1;
        end
        else if (pending_ops.size() != 0)
        begin
            op = pending_ops.pop_front();
            case (op.kind)
                OP_REQUEST:
                begin
                    nxt_start = 1'b1;
                    request   <= op.req;
                    gap_left  <= op.gap;
                end
                OP_REGISTER:
                begin
                    nxt_cfg_write = 1'b1;
                    cfg_index <= op.idx;
                    cfg_data  <= op.data;
                end
                default: drain_left <= SETTLE;
            endcase
        end
        start     <= nxt_start;
        cfg_write <= nxt_cfg_write;
    end

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    task automatic queue_register(input logic [bpp_pkg::CFG_IDX_W-1:0] idx, input longint value);
        pending_op_t op;
        op.kind = OP_REGISTER;
        op.gap  = 0;
        op.req  = '0;
        op.idx  = idx;
        op.data = value[31:0];
        if (idx == bpp_pkg::CFG_GRID_SPACING)
        begin
            gen_dx = (value[30:0] == 0) ? 1 : value[30:0];
        end
        if (idx == bpp_pkg::CFG_GRID_COUNT)
        begin
            gen_cnt = (value[10:0] < TABLE_DEPTH) ? value[10:0] : TABLE_DEPTH;
        end
        pending_ops.push_back(op);
    endtask

    task automatic queue_request(input bpp_pkg::req_t r, input bit steady);
        pending_op_t op;
        op.kind = OP_REQUEST;
        op.gap  = pick_gap(steady);
        op.req  = r;
        op.idx  = '0;
        op.data = '0;
        pending_ops.push_back(op);
        if (!r.mode)
        begin
            loads_sent++;
        end
    endtask

    task automatic queue_drain();
        pending_op_t op;
        op = '{OP_DRAIN, 0, '0, '0, '0};
        pending_ops.push_back(op);
    endtask

    task automatic queue_setting(input longint qm, dt, dx, cnt, bx, by, bz);
        queue_register(bpp_pkg::CFG_CHARGE_TO_MASS, qm);
        queue_register(bpp_pkg::CFG_TIME_STEP, dt);
        queue_register(bpp_pkg::CFG_GRID_SPACING, dx);
        queue_register(bpp_pkg::CFG_GRID_COUNT, cnt);
        queue_register(bpp_pkg::CFG_MAG_FIELD_X, bx);
        queue_register(bpp_pkg::CFG_MAG_FIELD_Y, by);
        queue_register(bpp_pkg::CFG_MAG_FIELD_Z, bz);
    endtask

    function automatic bpp_pkg::req_t make_load(input int idx, input int value);
        bpp_pkg::req_t r;
        r = '0;
        r.mode        = 1'b0;
        r.grid_index  = idx[9:0];
        r.field_value = value;
        return r;
    endfunction

    function automatic bpp_pkg::req_t make_push(input int vx, vy, vz, px, py, pz);
        bpp_pkg::req_t r;
        r = {1'b1, 10'($urandom), 32'($urandom), vx, vy, vz, px, py, pz};
        return r;
    endfunction

    function automatic int pick_value(input bit full);
        if (full)
        begin
            return $urandom;
        end
        return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endfunction

    function automatic int pick_pos_x();
        longint lim;
        int     r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return $urandom;
        end
        if (r == 1)
        begin
            return -int'($urandom_range(1, 1000));
        end
        lim = gen_cnt * gen_dx - 1;
        if (lim > 64'sd2147483647)
        begin
            lim = 64'sd2147483647;
        end
        if (r == 2)
        begin
            return int'(lim - $urandom_range(0, 3));
        end
        return $urandom_range(0, lim[31:0]);
    endfunction

    initial
    begin
        longint qm, dt, dx, cnt, bx, by, bz;
        bit     steady;
        bit     full;
        gen_dx  = 65536;
        gen_cnt = TABLE_DEPTH;
        foreach (field_table[i])
        begin
            field_table[i] = 0;
        end
        qm_reg = bpp_pkg::RST_CHARGE_TO_MASS;
        dt_reg = bpp_pkg::RST_TIME_STEP;
        dx_reg = bpp_pkg::RST_GRID_SPACING;
        cnt_reg = bpp_pkg::RST_GRID_COUNT;
        bx_reg = 0;
        by_reg = 0;
        bz_reg = 0;

        // directed: extremes, both modes, boundaries of the grid
        queue_setting(65536, 655, 65536, 1024, 0, 0, 0);
        queue_request(make_load(0, 32'sh7fffffff), 1);
        queue_request(make_load(1, 32'sh80000000), 1);
        queue_request(make_load(1023, 32'sh12345678), 1);
        queue_request(make_load(1022, -65536), 1);
        queue_request(make_push(0, 0, 0, 0, 0, 0), 1);
        queue_request(make_push(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                32'h00008000, 32'sh7fffffff, 32'sh80000000), 0);
        queue_request(make_push(32'sh80000000, 1, -1, -1, 0, 0), 0);
        queue_request(make_push(100, 200, 300, 32'sh80000000, 5, 5), 0);
        queue_request(make_push(100, 200, 300, 1023 << 16, 5, 5), 0);
        queue_request(make_push(100, 200, 300, (1023 << 16) + 32768, 5, 5), 0);
        queue_request(make_push(100, 200, 300, 1022 << 16, 5, 5), 0);
        queue_request(make_push(100, 200, 300, 1024 << 16, 5, 5), 0);
        queue_request(make_push(100, 200, 300, 32'sh7fffffff, 5, 5), 0);
        queue_drain();
        queue_setting(32'sh7fffffff, 31'h7fffffff, 0, 2, 32'sh7fffffff, 32'sh80000000, 65536);
        queue_request(make_push(65536, -65536, 32768, 0, 1, 1), 0);
        queue_request(make_push(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 1, 1), 0);
        queue_request(make_push(1, 2, 3, 2, 1, 1), 0);
        queue_drain();
        queue_setting(32'sh80000000, 0, 31'h7fffffff, 2047, 0, 0, 32'sh7fffffff);
        queue_request(make_push(-5, 7, 9, 32'sh7fffffff, 1, 1), 0);
        queue_request(make_push(-5, 7, 9, 0, 1, 1), 0);

        // random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            queue_drain();
            case (ph)
                0:
                begin
                    qm = 32'sh80000000; dt = 31'h7fffffff; dx = 1; cnt = 2;
                end
                1:
                begin
                    qm = 32'sh7fffffff; dt = 0; dx = 31'h7fffffff; cnt = 1024;
                end
                2:
                begin
                    qm = 65536; dt = 655; dx = 0; cnt = 1024;
                end
                default:
                begin
                    qm  = int'($urandom_range(0, 1 << 20)) - (1 << 19);
                    dt  = $urandom_range(1, 1 << 16);
                    dx  = $urandom_range(1 << 10, 1 << 18);
                    cnt = $urandom_range(2, 2047);
                end
            endcase
            full = (ph < 2) || ($urandom_range(0, 3) == 0);
            bx = pick_value(full);
            by = pick_value(full);
            bz = pick_value(full);
            queue_setting(qm, dt, dx, cnt, bx, by, bz);
            steady = (ph == 4);
            for (int n = 0; n < 115; n++)
            begin
                full = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) == 0)
                begin
                    queue_request(make_load(
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, gen_cnt - 1),
                        pick_value(full)), steady);
                end
                else
                begin
                    queue_request(make_push(pick_value(full), pick_value(full),
                                            pick_value(full), pick_pos_x(),
                                            pick_value(1), pick_value(1)), steady);
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_ops.size() != 0 || start || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        $display("Run covered %0d table loads and %0d pushes (%0d outside the grid)",
                 loads_sent, pushes_checked, outside_seen);
        $display("across 11 register settings, with %0d errors", errors);
        if (errors == 0)
        begin
            $display("boris_particle_push_with_field_gather_unit: match");
        end
        else
        begin
            $display("boris_particle_push_with_field_gather_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: boris_particle_push_with_field_gather_unit.f
rtl/core/bpp_pkg.sv
rtl/core/bpp_ram.sv
rtl/core/bpp_div_pipe.sv
rtl/core/bpp_gather.sv
rtl/core/bpp_boris.sv
rtl/core/boris_particle_push_with_field_gather_unit.sv
bench/boris_particle_push_with_field_gather_unit_tb.sv
